[rtl/core/bke_pkg.sv]
// Package for the button to keystroke encoder: item types, event word
// constants, the keysym table and the controller/datapath interface types.
// No dependencies.
package bke_pkg;

  localparam int NUM_BUTTONS_DEF = 9;
  localparam int BTN_W           = 9;
  localparam int WORD_W          = 15;
  localparam int SYM_W           = 9;
  localparam int MODE_W          = 2;

  localparam logic [WORD_W-1:0] WORD_FMT  = 15'h0400;
  localparam logic [WORD_W-1:0] MOD_SHIFT = 15'h1000;
  localparam logic [WORD_W-1:0] MOD_CTRL  = 15'h2000;
  localparam logic [WORD_W-1:0] WORD_REL  = 15'h4000;

  localparam logic [SYM_W-1:0] SYM_UP     = 9'h111;
  localparam logic [SYM_W-1:0] SYM_DOWN   = 9'h112;
  localparam logic [SYM_W-1:0] SYM_RIGHT  = 9'h113;
  localparam logic [SYM_W-1:0] SYM_LEFT   = 9'h114;
  localparam logic [SYM_W-1:0] SYM_SPACE  = 9'd32;
  localparam logic [SYM_W-1:0] SYM_LSHIFT = 9'd304;
  localparam logic [SYM_W-1:0] SYM_LCTRL  = 9'd306;
  localparam logic [SYM_W-1:0] SYM_Y      = 9'd121;
  localparam logic [SYM_W-1:0] SYM_RETURN = 9'd13;
  localparam logic [SYM_W-1:0] SYM_NONE   = 9'd0;

  localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEYBOARD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOUSE    = 2'd2;

  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic             toggle_button;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] event_word;
    logic [MODE_W-1:0] overlay_mode;
    logic              last;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic pending_none;
    logic row_pending;
    logic slot_free;
  } dp_status_t;

  function automatic logic [SYM_W-1:0] keysym(input logic [3:0] row);
    logic [SYM_W-1:0] sym;
    case (row)
      4'd0:    sym = SYM_UP;
      4'd1:    sym = SYM_DOWN;
      4'd2:    sym = SYM_LEFT;
      4'd3:    sym = SYM_RIGHT;
      4'd4:    sym = SYM_SPACE;
      4'd5:    sym = SYM_LCTRL;
      4'd6:    sym = SYM_Y;
      4'd7:    sym = SYM_LSHIFT;
      4'd8:    sym = SYM_RETURN;
      default: sym = SYM_NONE;
    endcase
    return sym;
  endfunction

  function automatic logic [WORD_W-1:0] sym_mod(input logic [SYM_W-1:0] sym);
    logic [WORD_W-1:0] m;
    if (sym == SYM_LSHIFT) begin
      m = MOD_SHIFT;
    end else if (sym == SYM_LCTRL) begin
      m = MOD_CTRL;
    end else begin
      m = '0;
    end
    return m;
  endfunction

endpackage

[rtl/core/bke_ctrl.sv]
// Controller state machine of the button to keystroke encoder.
// Depends on bke_pkg for the state, command and status types.
module bke_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bke_pkg::dp_status_t status,
  output bke_pkg::ctl_cmd_t   cmd
);
  import bke_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        // No item is taken while reset is held.
        in_ready = ~rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.pending_none) begin
          state_next = ST_IDLE;
        end else if (status.row_pending) begin
          // A row with an event waits here until the output slot frees up.
          if (status.slot_free) begin
            cmd.emit = 1'b1;
            cmd.step = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/bke_datapath.sv]
// Datapath of the button to keystroke encoder: level and mode state,
// per-frame event mask, row scan counter and the output register.
// Depends on bke_pkg for types, constants and the keysym table.
module bke_datapath #(
  parameter int NUM_BUTTONS = bke_pkg::NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bke_pkg::in_item_t   in_item,
  input  bke_pkg::ctl_cmd_t   cmd,
  output bke_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output bke_pkg::out_item_t  out_item
);
  import bke_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int PAD_W = (NUM_BUTTONS > BTN_W) ? NUM_BUTTONS : BTN_W;

  logic [NUM_BUTTONS-1:0] prev_levels;
  logic                   toggle_prev;
  logic [MODE_W-1:0]      mode;
  logic [NUM_BUTTONS-1:0] live_q;
  logic [NUM_BUTTONS-1:0] pending;
  logic                   rel_all;
  logic [WORD_W-1:0]      held_q;
  logic [IDX_W-1:0]       idx;

  logic [PAD_W-1:0]       btn_wide;
  logic [NUM_BUTTONS-1:0] live;
  logic [NUM_BUTTONS-1:0] mapped;
  logic [WORD_W-1:0]      held;
  logic                   rise;
  logic                   was_up;
  logic                   opening;
  logic [NUM_BUTTONS-1:0] pending_load;
  logic [MODE_W-1:0]      mode_next;
  logic [NUM_BUTTONS-1:0] row_bit;
  logic [NUM_BUTTONS-1:0] remaining;
  logic [SYM_W-1:0]       sym;
  logic                   release_row;
  logic [WORD_W-1:0]      word;

  assign btn_wide = PAD_W'(in_item.buttons);
  assign live     = btn_wide[NUM_BUTTONS-1:0];
  assign rise     = in_item.toggle_button & ~toggle_prev;
  assign was_up   = (mode != MODE_OFF);
  assign opening  = rise & ~was_up;

  always_comb begin
    mapped = '0;
    held   = '0;
    for (int r = 0; r < NUM_BUTTONS; r++) begin
      mapped[r] = (keysym(4'(r)) != SYM_NONE);
      if (live[r]) begin
        held = held | sym_mod(keysym(4'(r)));
      end
    end
  end

  always_comb begin
    if (opening) begin
      pending_load = prev_levels & mapped;
    end else if (was_up) begin
      pending_load = '0;
    end else begin
      pending_load = (live ^ prev_levels) & mapped;
    end
  end

  always_comb begin
    mode_next = mode;
    if (rise) begin
      case (mode)
        MODE_OFF:      mode_next = MODE_KEYBOARD;
        MODE_KEYBOARD: mode_next = MODE_MOUSE;
        default:       mode_next = MODE_OFF;
      endcase
    end
  end

  assign row_bit     = NUM_BUTTONS'(1) << idx;
  assign remaining   = pending & ~row_bit;
  assign sym         = keysym(4'(idx));
  assign release_row = rel_all | ~live_q[idx];

  always_comb begin
    word = WORD_FMT | WORD_W'(sym);
    if (release_row) begin
      word = word | WORD_REL;
    end else if (sym_mod(sym) == '0) begin
      word = word | held_q;
    end
  end

  assign status.pending_none = (pending == '0);
  assign status.row_pending  = pending[idx];
  assign status.slot_free    = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      toggle_prev <= 1'b0;
      mode        <= MODE_OFF;
      pending     <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        prev_levels <= live;
        toggle_prev <= in_item.toggle_button;
        mode        <= mode_next;
        pending     <= pending_load;
        idx         <= '0;
      end else begin
        if (cmd.emit) begin
          pending <= remaining;
        end
        if (cmd.step) begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      live_q  <= live;
      rel_all <= opening;
      held_q  <= held;
    end
    if (cmd.emit) begin
      out_item.event_word   <= word;
      out_item.overlay_mode <= mode;
      out_item.last         <= (remaining == '0);
    end
  end

endmodule

[rtl/core/button_to_keystroke_encoder_top.sv]
// Top level of the button to keystroke encoder.
// Instantiates bke_ctrl and bke_datapath; depends on bke_pkg.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   in_item  (buttons, toggle_button)
// output    out        out_valid / out_ready out_item (event_word, overlay_mode, last)
//
// A frame is taken while the controller is idle, then the rows are scanned
// one per cycle by the row scan counter in the datapath, as long as the
// output side takes every item at once.
// Reset clears the button levels, the toggle history and the overlay mode,
// and in_ready stays low while reset is held.
// A stalled output holds the scan on the row whose word is waiting; the
// next frame is accepted as soon as the scan ends, even while the final
// word of the previous frame still sits in the output register.
module button_to_keystroke_encoder_top #(
  parameter int NUM_BUTTONS = bke_pkg::NUM_BUTTONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bke_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output bke_pkg::out_item_t out_item
);
  import bke_pkg::*;

  // Commands from the controller and status from the datapath are the only
  // connection between the two halves.
  ctl_cmd_t   cmd;
  dp_status_t status;

  // The controller accepts a frame when idle and then paces the row scan.
  bke_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath computes the event mask on load and builds one word for
  // each pending row as the scan reaches it.
  bke_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for button_to_keystroke_encoder_top: directed button frames,
// then random ones, checked against a predictor of the key event words.
// Depends on bke_pkg and the button_to_keystroke_encoder_top RTL.
`timescale 1ns / 100ps

module testbench;
  import bke_pkg::*;

  // Rows of the keypad as this testbench sees them; the RTL keeps its own table.
  localparam int NUM_ROWS = 9;
  localparam logic [NUM_ROWS-1:0][SYM_W-1:0] ROW_SYM = {
    SYM_RETURN, SYM_LSHIFT, SYM_Y, SYM_LCTRL, SYM_SPACE,
    SYM_RIGHT, SYM_LEFT, SYM_DOWN, SYM_UP
  };

  // The drain covers a frame's full row scan, with slack.
  localparam int DRAIN_CYCLES   = NUM_ROWS + 12;
  // Slowest correct run: about 420 frames, each emitting nine words that each wait
  // out a long receiver stall, plus the sender's gaps. This limit lies well above
  // that.
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RAND_PER_PHASE = 131;
  localparam int MAX_REPORTS    = 10;

  // One directed frame. A typed row carries up to two expected words read straight
  // off the encoding rules (overlay off, last flag on the final word). Other rows
  // are checked against the predictor.
  typedef struct packed {
    in_item_t          frame;
    logic              typed;
    logic [1:0]        n_words;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Predictor state: levels seen at the last frame, toggle history, overlay mode.
  logic [BTN_W-1:0]  lvl_prev = '0;
  logic              tog_prev = 1'b0;
  logic [MODE_W-1:0] ovl_mode = MODE_OFF;

  out_item_t expected_events[$];
  stim_row_t stim_rows[$];
  out_item_t want_event;
  int        mismatches    = 0;
  int        cycle_count   = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  button_to_keystroke_encoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[button_to_keystroke_encoder_top] ERROR");
      $finish;
    end
  end

  // The receiver stalls at random. The percentage changes with the phase of the run.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted output item is compared with the oldest expected word.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected event: word %h mode %0d last %0d",
                   out_item.event_word, out_item.overlay_mode, out_item.last);
        end
      end else begin
        want_event = expected_events.pop_front();
        if (out_item.event_word !== want_event.event_word ||
            out_item.overlay_mode !== want_event.overlay_mode ||
            out_item.last !== want_event.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("event mismatch: expected word %h mode %0d last %0d, got %h %0d %0d",
                     want_event.event_word, want_event.overlay_mode, want_event.last,
                     out_item.event_word, out_item.overlay_mode, out_item.last);
          end
        end
      end
    end
  end

  // Predictor. It advances the keypad state by one frame and, when publish is set,
  // queues the event words that the frame should produce.
  task automatic encode_frame(input in_item_t f, input bit publish);
    logic [WORD_W-1:0] words[$];
    logic [WORD_W-1:0] held;
    logic [WORD_W-1:0] w;
    logic [SYM_W-1:0]  sym;
    logic              was_up;
    out_item_t         ev;
    int                i;
    was_up = (ovl_mode != MODE_OFF);
    held   = '0;
    // A rising edge of the toggle opens the overlay from off. First it releases
    // every key that is still held, in table order.
    if (f.toggle_button && !tog_prev) begin
      if (!was_up) begin
        for (i = 0; i < NUM_ROWS; i++) begin
          sym = ROW_SYM[i];
          if (lvl_prev[i] && sym != SYM_NONE) words.push_back(WORD_FMT | sym | WORD_REL);
        end
        lvl_prev = '0;
      end
      ovl_mode = (ovl_mode == MODE_MOUSE) ? MODE_OFF : ovl_mode + 2'd1;
    end
    tog_prev = f.toggle_button;
    // Beyond those releases, no words come while the overlay is up, on the frame that
    // opens it, or on the frame that closes it. Otherwise each changed row gives one word.
    if (ovl_mode == MODE_OFF && !was_up) begin
      for (i = 0; i < NUM_ROWS; i++) begin
        if (f.buttons[i] && ROW_SYM[i] == SYM_LSHIFT) held = held | MOD_SHIFT;
        if (f.buttons[i] && ROW_SYM[i] == SYM_LCTRL)  held = held | MOD_CTRL;
      end
      for (i = 0; i < NUM_ROWS; i++) begin
        sym = ROW_SYM[i];
        if (f.buttons[i] != lvl_prev[i] && sym != SYM_NONE) begin
          if (f.buttons[i]) begin
            w = WORD_FMT | sym;
            // A modifier key does not take modifier bits on its own press.
            if (sym != SYM_LSHIFT && sym != SYM_LCTRL) w = w | held;
          end else begin
            w = WORD_FMT | sym | WORD_REL;
          end
          words.push_back(w);
        end
      end
    end
    lvl_prev = f.buttons;
    if (publish) begin
      for (i = 0; i < words.size(); i++) begin
        ev.event_word   = words[i];
        ev.overlay_mode = ovl_mode;
        ev.last         = (i == words.size() - 1);
        expected_events.push_back(ev);
      end
    end
  endtask

  // Offers one frame after an optional random gap and waits for the handshake.
  // Then it queues the expected words, either typed in or from the predictor.
  // Valid is held, with the payload steady, until the item is taken.
  task automatic apply_frame(input in_item_t f, input bit typed, input int n_typed,
                             input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
    out_item_t ev;
    int        k;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= f;
    do @(posedge clk); while (!in_ready);
    encode_frame(f, !typed);
    if (typed) begin
      for (k = 0; k < n_typed; k++) begin
        ev.event_word   = (k == 0) ? w0 : w1;
        ev.overlay_mode = MODE_OFF;
        ev.last         = (k == n_typed - 1);
        expected_events.push_back(ev);
      end
    end
  endtask

  task automatic add_row(input logic [BTN_W-1:0] btn, input logic tog, input logic typed,
                         input logic [1:0] n, input logic [WORD_W-1:0] w0,
                         input logic [WORD_W-1:0] w1);
    stim_row_t row;
    row.frame.buttons       = btn;
    row.frame.toggle_button = tog;
    row.typed               = typed;
    row.n_words             = n;
    row.w0                  = w0;
    row.w1                  = w1;
    stim_rows.push_back(row);
  endtask

  // Pauses the sender until every word that is still expected has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_events.size() != 0);
  endtask

  initial begin
    in_item_t         f;
    logic [BTN_W-1:0] btn;
    logic             tog;
    int               phase;
    int               k;
    int               pick;
    int               flip_pct;

    // Directed frames. Each one walks the keypad through a known situation.
    add_row(9'h000, 1'b0, 1'b1, 2'd0, '0, '0);         // quiet frame straight after reset
    add_row(9'h001, 1'b0, 1'b1, 2'd1, 15'h0511, '0);   // up pressed alone
    add_row(9'h000, 1'b0, 1'b1, 2'd1, 15'h4511, '0);   // up released
    add_row(9'h1FF, 1'b0, 1'b0, 2'd0, '0, '0);         // every key pressed in one frame
    add_row(9'h000, 1'b0, 1'b0, 2'd0, '0, '0);         // every key released
    add_row(9'h080, 1'b0, 1'b1, 2'd1, 15'h0530, '0);   // shift itself takes no modifier
    add_row(9'h081, 1'b0, 1'b1, 2'd1, 15'h1511, '0);   // up with shift held
    add_row(9'h0A1, 1'b0, 1'b1, 2'd1, 15'h0532, '0);   // ctrl pressed while shift held
    add_row(9'h0A3, 1'b0, 1'b0, 2'd0, '0, '0);         // down with shift and ctrl held
    add_row(9'h0A3, 1'b1, 1'b0, 2'd0, '0, '0);         // overlay opens and releases held keys
    add_row(9'h1FF, 1'b1, 1'b1, 2'd0, '0, '0);         // overlay up: levels tracked, no words
    add_row(9'h000, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(9'h004, 1'b1, 1'b1, 2'd0, '0, '0);         // keyboard to mouse
    add_row(9'h004, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(9'h010, 1'b1, 1'b1, 2'd0, '0, '0);         // overlay closes, still silent
    add_row(9'h000, 1'b0, 1'b1, 2'd1, 15'h4420, '0);   // space release seen after closing
    add_row(9'h100, 1'b0, 1'b1, 2'd1, 15'h040D, '0);   // return
    add_row(9'h140, 1'b0, 1'b1, 2'd1, 15'h0479, '0);   // y
    add_row(9'h140, 1'b1, 1'b0, 2'd0, '0, '0);         // opens with two keys held
    add_row(9'h000, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(9'h000, 1'b1, 1'b1, 2'd0, '0, '0);
    add_row(9'h000, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(9'h1FF, 1'b1, 1'b1, 2'd0, '0, '0);         // closes with every key down
    add_row(9'h1FF, 1'b0, 1'b1, 2'd0, '0, '0);         // no change, no words
    add_row(9'h000, 1'b1, 1'b0, 2'd0, '0, '0);         // opens with all nine held
    add_row(9'h000, 1'b1, 1'b1, 2'd0, '0, '0);         // toggle held, no new edge

    send_idle_pct = 16;
    recv_idle_pct = 61;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < stim_rows.size(); k++) begin
      apply_frame(stim_rows[k].frame, stim_rows[k].typed, int'(stim_rows[k].n_words),
                  stim_rows[k].w0, stim_rows[k].w1);
    end

    // Random frames. Most of them change a few levels, as a player would, so
    // the off mode produces plenty of words. The toggle flips seldom while the
    // overlay is off and more often while it is up, so that it soon closes again.
    btn = stim_rows[stim_rows.size() - 1].frame.buttons;
    tog = stim_rows[stim_rows.size() - 1].frame.toggle_button;
    for (phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        if (k == RAND_PER_PHASE / 2) wait_drained();
        pick = $urandom_range(99);
        if (pick < 45) begin
          btn = btn ^ (BTN_W'(1) << $urandom_range(BTN_W - 1));
        end else if (pick < 65) begin
          btn = btn ^ BTN_W'($urandom_range(511));
        end else if (pick < 80) begin
          btn = BTN_W'($urandom_range(511));
        end else if (pick < 86) begin
          btn = '0;
        end else if (pick < 92) begin
          btn = '1;
        end
        flip_pct = (ovl_mode == MODE_OFF) ? 8 : 30;
        if ($urandom_range(99) < flip_pct) tog = ~tog;
        f.buttons       = btn;
        f.toggle_button = tog;
        apply_frame(f, 1'b0, 0, '0, '0);
      end
    end

    // Let every expected word arrive, then give the block time to show any
    // stray words before the verdict is taken between clock edges.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("[button_to_keystroke_encoder_top] OK");
    end else begin
      $display("[button_to_keystroke_encoder_top] ERROR");
    end
    $finish;
  end

endmodule
